### rtl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

  localparam logic [7:0] HEAD_FIRST     = 8'hA5;
  localparam logic [7:0] HEAD_SECOND    = 8'h5A;
  localparam int         FRAME_OVERHEAD = 4;
  localparam int         CAPTURE_DEPTH  = 10;
  localparam int         CAP_IDX_W      = 4;
  localparam int         TDATA_W        = 96;

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_HEAD = 2'd2;
  localparam logic [1:0] ST_LONG = 2'd3;

  typedef struct packed {
    logic [7:0]  status_low;
    logic [7:0]  status_high;
    logic [15:0] target_y;
    logic [15:0] target_x;
    logic [15:0] right_distance;
    logic [15:0] left_distance;
    logic [7:0]  payload_length;
    logic [1:0]  frame_status;
  } result_t;

endpackage
`default_nettype wire

### rtl/sfd_parser.sv
`default_nettype none
module sfd_parser #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire  [7:0]        rx_byte,
  output logic              res_valid,
  output sfd_pkg::result_t  res
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_HEAD2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  logic [2:0] phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] captured [sfd_pkg::CAPTURE_DEPTH];
  logic       cap_clear;
  logic       cap_write;
  logic [7:0] seen_inc;
  logic       too_long;

  assign seen_inc = bytes_seen + 8'd1;
  assign too_long = ({2'b00, rx_byte} + 10'(sfd_pkg::FRAME_OVERHEAD)) > 10'(MAX_FRAME_BYTES);

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    cap_clear         = 1'b0;
    cap_write         = 1'b0;
    res_valid         = 1'b0;
    res               = '0;
    case (phase)
      PH_HEAD2: begin
        if (rx_byte == sfd_pkg::HEAD_SECOND) begin
          phase_next = PH_LEN;
        end else begin
          // a repeated first header byte keeps the hunt one step ahead
          phase_next       = (rx_byte == sfd_pkg::HEAD_FIRST) ? PH_HEAD2 : PH_HUNT;
          res_valid        = 1'b1;
          res.frame_status = sfd_pkg::ST_HEAD;
        end
      end
      PH_LEN: begin
        frame_length_next = rx_byte;
        bytes_seen_next   = '0;
        running_sum_next  = '0;
        cap_clear         = 1'b1;
        if (too_long) begin
          phase_next         = PH_HUNT;
          res_valid          = 1'b1;
          res.frame_status   = sfd_pkg::ST_LONG;
          res.payload_length = rx_byte;
        end else begin
          phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        cap_write        = bytes_seen < 8'(sfd_pkg::CAPTURE_DEPTH);
        running_sum_next = running_sum + rx_byte;
        bytes_seen_next  = seen_inc;
        if (seen_inc >= frame_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_next         = PH_HUNT;
        res_valid          = 1'b1;
        res.payload_length = frame_length;
        if (rx_byte != running_sum) begin
          res.frame_status = sfd_pkg::ST_SUM;
        end else begin
          res.frame_status   = sfd_pkg::ST_GOOD;
          res.left_distance  = {captured[0], captured[1]};
          res.right_distance = {captured[2], captured[3]};
          res.target_x       = {captured[4], captured[5]};
          res.target_y       = {captured[6], captured[7]};
          res.status_high    = captured[8];
          res.status_low     = captured[9];
        end
      end
      default: begin
        phase_next = (rx_byte == sfd_pkg::HEAD_FIRST) ? PH_HEAD2 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      bytes_seen   <= '0;
      running_sum  <= '0;
    end else if (en) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      running_sum  <= running_sum_next;
    end
  end

  // payload bytes are cleared at every length byte, so no reset is needed
  always_ff @(posedge clk) begin
    if (en && cap_clear) begin
      for (int i = 0; i < sfd_pkg::CAPTURE_DEPTH; i++) begin
        captured[i] <= '0;
      end
    end else if (en && cap_write) begin
      captured[bytes_seen[sfd_pkg::CAP_IDX_W-1:0]] <= rx_byte;
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT || phase == PH_HEAD2 || phase == PH_LEN ||
    phase == PH_DATA || phase == PH_CHECK)
    else $error("parse phase left the legal range");

  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> phase == PH_HEAD2 || phase == PH_LEN || phase == PH_CHECK)
    else $error("result raised outside a phase that can end a frame");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_status != sfd_pkg::ST_GOOD |->
      res.left_distance == '0 && res.right_distance == '0 &&
      res.target_x == '0 && res.target_y == '0 &&
      res.status_high == '0 && res.status_low == '0)
    else $error("error result carries payload");

  a_len_restart: assert property (@(posedge clk) disable iff (rst)
    en && phase == PH_LEN |=> bytes_seen == '0 && running_sum == '0)
    else $error("length byte did not restart the count and sum");

  a_data_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_seen < frame_length)
    else $error("payload count ran past the frame length");

endmodule
`default_nettype wire

### rtl/sfd_out_reg.sv
`default_nettype none
module sfd_out_reg (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              load,
  input  wire  sfd_pkg::result_t           res,
  input  wire                              ready,
  output logic                             valid,
  output logic [sfd_pkg::TDATA_W-1:0]      tdata
);

  localparam int PAD_W = sfd_pkg::TDATA_W - $bits(sfd_pkg::result_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // struct is declared last field first, so frame_status lands in the low bits
  always_ff @(posedge clk) begin
    if (load) begin
      tdata <= {{PAD_W{1'b0}}, res};
    end
  end

endmodule
`default_nettype wire

### rtl/serial_frame_deframer_sum_check.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata[7:0]  rx_byte
// m_        out        m_tvalid/m_tready  m_tdata[95:0] status, length, distances, targets
//
// One byte is taken per cycle while s_tready is high. A byte is held in the input register
// until it is parsed; its result (if any) is then loaded into the output register, which
// raises m_tvalid. s_tready falls only while both the input and output
// registers are full and m_tready is low. Reset (rst, synchronous) returns the parser to
// hunting for the first header byte and empties both registers; no clearing pass.
module serial_frame_deframer_sum_check #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [7:0]                   s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // [1:0] frame_status, [9:2] payload_length, [25:10] left_distance,
  // [41:26] right_distance, [57:42] target_x, [73:58] target_y,
  // [81:74] status_high, [89:82] status_low, [95:90] zero
  output logic [sfd_pkg::TDATA_W-1:0]  m_tdata
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  logic             res_valid;
  sfd_pkg::result_t res;

  // parse only when the output slot is free or draining this cycle
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  sfd_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance && res_valid),
    .res   (res),
    .ready (m_tready),
    .valid (m_tvalid),
    .tdata (m_tdata)
  );

endmodule
`default_nettype wire
